@@ rtl/cwc_pkg.sv @@
package cwc_pkg;

   // Window length and store geometry
   localparam int WIN_LEN     = 64;
   localparam int STORE_DEPTH = 64;
   localparam int ADDR_W      = 6;

   // Field and arithmetic widths
   localparam int SMP_W  = 16;
   localparam int WORD_W = 2 * SMP_W;
   localparam int PROD_W = 2 * SMP_W;
   localparam int TERM_W = PROD_W + 1;
   localparam int ACC_W  = 39;

   localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(WIN_LEN - 1);

   localparam logic MODE_COEF   = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   typedef logic [ADDR_W-1:0] addr_type;

   // Controller to datapath commands
   typedef struct packed {
      logic     wr_win;
      logic     wr_smp;
      addr_type wr_addr;
      logic     issue;
      addr_type rd_k;
      addr_type rd_w;
      logic     first;
      logic     last;
      addr_type lag;
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic adv;
   } dp_status_type;

endpackage

@@ rtl/cwc_if.sv @@
interface cwc_req_if;
   import cwc_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    mode;
   logic [ADDR_W-1:0]       coef_index;
   logic signed [SMP_W-1:0] value_re;
   logic signed [SMP_W-1:0] value_im;

   modport source (output valid, mode, coef_index, value_re, value_im, input ready);
   modport sink   (input valid, mode, coef_index, value_re, value_im, output ready);
endinterface

interface cwc_rsp_if;
   import cwc_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [ACC_W-1:0] out_re;
   logic signed [ACC_W-1:0] out_im;
   logic [ADDR_W-1:0]       lag;
   logic                    last;

   modport source (output valid, out_re, out_im, lag, last, input ready);
   modport sink   (input valid, out_re, out_im, lag, last, output ready);
endinterface

@@ rtl/circular_window_correlator.sv @@
// Channel   Dir  Fields                                  Word moved when
// req_chan  in   mode, coef_index, value_re, value_im    valid && ready
// rsp_chan  out  out_re, out_im, lag, last                valid && ready
//
// A coefficient word or a sample word that does not close a vector leaves the block idle, ready for the next word.
// The word that closes a vector starts WIN_LEN lags of WIN_LEN complex MACs each, one
// MAC per cycle on the single multiplier set while no result stalls; each lag's sum
// goes out through the store read, product, term, accumulator and output registers.
// Reset clears the controller and pipe valids; window and sample stores hold garbage.
// A stalled result freezes the MAC pipe; new words wait until all lags are issued.
module circular_window_correlator (
   input logic      clock,
   input logic      reset,
   cwc_req_if.sink  req_chan,
   cwc_rsp_if.source rsp_chan
);
   import cwc_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Sequence the loads, the sample count and the lag/tap loop
   cwc_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_mode       (req_chan.mode),
      .req_coef_index (req_chan.coef_index),
      .req_ready      (req_chan.ready),
      .status         (status),
      .cmd            (cmd)
   );

   // Hold both stores, run the complex MAC pipe and the result register
   cwc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .value_re  (req_chan.value_re),
      .value_im  (req_chan.value_im),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_re    (rsp_chan.out_re),
      .rsp_im    (rsp_chan.out_im),
      .rsp_lag   (rsp_chan.lag),
      .rsp_last  (rsp_chan.last)
   );

endmodule

@@ rtl/cwc_ram.sv @@
module cwc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/cwc_ctrl.sv @@
module cwc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_mode,
   input  cwc_pkg::addr_type      req_coef_index,
   output logic                   req_ready,
   input  cwc_pkg::dp_status_type status,
   output cwc_pkg::ctrl_cmd_type  cmd
);
   import cwc_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type state_ff, state_in;
   addr_type  count_ff, count_in;
   addr_type  j_ff, j_in;
   addr_type  k_ff, k_in;
   addr_type  w_ff, w_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd.wr_win  = accept && (req_mode == MODE_COEF);
      cmd.wr_smp  = accept && (req_mode == MODE_SAMPLE);
      cmd.wr_addr = (req_mode == MODE_SAMPLE) ? count_ff : req_coef_index;
      cmd.issue   = (state_ff == ST_RUN);
      cmd.rd_k    = k_ff;
      cmd.rd_w    = w_ff;
      cmd.first   = (k_ff == '0);
      cmd.last    = (k_ff == LAST_IDX);
      cmd.lag     = j_ff;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      w_in     = w_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.wr_smp) begin
               if (count_ff == LAST_IDX) begin
                  count_in = '0;
                  j_in     = '0;
                  k_in     = '0;
                  w_in     = '0;
                  state_in = ST_RUN;
               end else begin
                  count_in = count_ff + ADDR_W'(1);
               end
            end
         end
         ST_RUN: begin
            if (status.adv) begin
               if (k_ff == LAST_IDX) begin
                  k_in = '0;
                  if (j_ff == LAST_IDX) begin
                     state_in = ST_IDLE;
                  end else begin
                     j_in = j_ff + ADDR_W'(1);
                     w_in = j_ff + ADDR_W'(1);
                  end
               end else begin
                  k_in = k_ff + ADDR_W'(1);
                  w_in = (w_ff == LAST_IDX) ? '0 : w_ff + ADDR_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         w_ff     <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         w_ff     <= w_in;
      end
   end

endmodule

@@ rtl/cwc_dp.sv @@
module cwc_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  cwc_pkg::ctrl_cmd_type        cmd,
   output cwc_pkg::dp_status_type       status,
   input  logic signed [cwc_pkg::SMP_W-1:0] value_re,
   input  logic signed [cwc_pkg::SMP_W-1:0] value_im,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic signed [cwc_pkg::ACC_W-1:0] rsp_re,
   output logic signed [cwc_pkg::ACC_W-1:0] rsp_im,
   output cwc_pkg::addr_type            rsp_lag,
   output logic                         rsp_last
);
   import cwc_pkg::*;

   logic [WORD_W-1:0] wdata;
   logic [WORD_W-1:0] smp_q;
   logic [WORD_W-1:0] win_q;
   logic              adv;
   logic              load;
   logic              rd_en;

   logic signed [SMP_W-1:0]  xr, xi, wr, wi;
   logic signed [PROD_W-1:0] prr_ff, pii_ff, pri_ff, pir_ff;
   logic signed [TERM_W-1:0] tre_ff, tim_ff;
   logic signed [ACC_W-1:0]  acc_re_ff, acc_im_ff;
   logic signed [ACC_W-1:0]  out_re_ff, out_im_ff;
   addr_type                 out_lag_ff;
   logic                     out_last_ff;
   logic                     out_valid_ff;

   logic     v1_ff, v2_ff, v3_ff, done4_ff;
   logic     first1_ff, first2_ff, first3_ff;
   logic     last1_ff, last2_ff, last3_ff;
   addr_type lag1_ff, lag2_ff, lag3_ff, lag4_ff;

   assign wdata = {value_re, value_im};
   assign rd_en = cmd.issue && adv;

   cwc_ram #(.WIDTH(WORD_W), .DEPTH(STORE_DEPTH)) u_win_ram (
      .clock (clock),
      .we    (cmd.wr_win),
      .waddr (cmd.wr_addr),
      .wdata (wdata),
      .re    (rd_en),
      .raddr (cmd.rd_w),
      .rdata (win_q)
   );

   cwc_ram #(.WIDTH(WORD_W), .DEPTH(STORE_DEPTH)) u_smp_ram (
      .clock (clock),
      .we    (cmd.wr_smp),
      .waddr (cmd.wr_addr),
      .wdata (wdata),
      .re    (rd_en),
      .raddr (cmd.rd_k),
      .rdata (smp_q)
   );

   assign xr = smp_q[WORD_W-1:SMP_W];
   assign xi = smp_q[SMP_W-1:0];
   assign wr = win_q[WORD_W-1:SMP_W];
   assign wi = win_q[SMP_W-1:0];

   // hold the whole pipe while a finished sum waits for a full output register
   assign load       = done4_ff && (!out_valid_ff || rsp_ready);
   assign adv        = !done4_ff || load;
   assign status.adv = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         done4_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            v1_ff    <= rd_en;
            v2_ff    <= v1_ff;
            v3_ff    <= v2_ff;
            done4_ff <= v3_ff && last3_ff;
         end
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         first1_ff <= cmd.first;
         last1_ff  <= cmd.last;
         lag1_ff   <= cmd.lag;
         first2_ff <= first1_ff;
         last2_ff  <= last1_ff;
         lag2_ff   <= lag1_ff;
         first3_ff <= first2_ff;
         last3_ff  <= last2_ff;
         lag3_ff   <= lag2_ff;
         lag4_ff   <= lag3_ff;

         prr_ff <= xr * wr;
         pii_ff <= xi * wi;
         pri_ff <= xr * wi;
         pir_ff <= xi * wr;

         tre_ff <= TERM_W'(prr_ff) - TERM_W'(pii_ff);
         tim_ff <= TERM_W'(pri_ff) + TERM_W'(pir_ff);

         if (v3_ff) begin
            if (first3_ff) begin
               acc_re_ff <= ACC_W'(tre_ff);
               acc_im_ff <= ACC_W'(tim_ff);
            end else begin
               acc_re_ff <= acc_re_ff + ACC_W'(tre_ff);
               acc_im_ff <= acc_im_ff + ACC_W'(tim_ff);
            end
         end
      end
      if (load) begin
         out_re_ff   <= acc_re_ff;
         out_im_ff   <= acc_im_ff;
         out_lag_ff  <= lag4_ff;
         out_last_ff <= (lag4_ff == LAST_IDX);
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_re    = out_re_ff;
   assign rsp_im    = out_im_ff;
   assign rsp_lag   = out_lag_ff;
   assign rsp_last  = out_last_ff;

endmodule

@@ dv/testbench.sv @@
module testbench;
   import cwc_pkg::*;

   // Stop the run at this cycle count if the results stop coming.
   localparam int CYCLE_LIMIT = 600000;
   // Wait this long after the last result to catch stray extra results.
   localparam int DRAIN_CYCLES = 40;
   localparam int IDLE_PCT = 23;
   localparam int HOLDOFF_CYCLES = 400;

   // One correlation output: one lag of one completed vector.
   typedef struct {
      logic signed [ACC_W-1:0] re;
      logic signed [ACC_W-1:0] im;
      addr_type                lag;
      logic                    last;
   } corr_result_t;

   // Keep a shadow copy of the window and the sample vector, and queue the
   // correlation of every completed vector.
   class corr_scoreboard;
      logic signed [SMP_W-1:0] win_re [WIN_LEN];
      logic signed [SMP_W-1:0] win_im [WIN_LEN];
      logic signed [SMP_W-1:0] smp_re [WIN_LEN];
      logic signed [SMP_W-1:0] smp_im [WIN_LEN];
      addr_type                smp_fill;
      corr_result_t            lag_q[$];
      int                      errors;

      function new();
         smp_fill = '0;
         errors   = 0;
      endfunction

      task report_mismatch(input string what);
         errors++;
         if (errors <= 40)
            $display("ERROR at %0t: %s", $realtime, what);
      endtask

      function void note_word(input logic mode, input addr_type idx,
                              input logic signed [SMP_W-1:0] re,
                              input logic signed [SMP_W-1:0] im);
         corr_result_t r;
         longint       acc_re;
         longint       acc_im;
         int           w;
         if (mode == MODE_COEF) begin
            win_re[idx] = re;
            win_im[idx] = im;
            return;
         end
         smp_re[smp_fill] = re;
         smp_im[smp_fill] = im;
         if (smp_fill != LAST_IDX) begin
            smp_fill++;
            return;
         end
         smp_fill = '0;
         for (int j = 0; j < WIN_LEN; j++) begin
            acc_re = 0;
            acc_im = 0;
            for (int k = 0; k < WIN_LEN; k++) begin
               w = (j + k) % WIN_LEN;
               acc_re += longint'(smp_re[k]) * longint'(win_re[w])
                       - longint'(smp_im[k]) * longint'(win_im[w]);
               acc_im += longint'(smp_re[k]) * longint'(win_im[w])
                       + longint'(smp_im[k]) * longint'(win_re[w]);
            end
            r.re   = acc_re[ACC_W-1:0];
            r.im   = acc_im[ACC_W-1:0];
            r.lag  = addr_type'(j);
            r.last = (j == WIN_LEN - 1);
            lag_q.push_back(r);
         end
      endfunction

      task check_result(input logic signed [ACC_W-1:0] re,
                        input logic signed [ACC_W-1:0] im,
                        input addr_type lag, input logic last);
         corr_result_t e;
         if (lag_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result lag %0d re %0d im %0d",
                                      lag, re, im));
            return;
         end
         e = lag_q.pop_front();
         if (re !== e.re)
            report_mismatch($sformatf("lag %0d re %0d, want %0d", e.lag, re, e.re));
         if (im !== e.im)
            report_mismatch($sformatf("lag %0d im %0d, want %0d", e.lag, im, e.im));
         if (lag !== e.lag)
            report_mismatch($sformatf("lag %0d, want %0d", lag, e.lag));
         if (last !== e.last)
            report_mismatch($sformatf("lag %0d last %b, want %b", e.lag, last, e.last));
      endtask
   endclass

   logic clock;
   logic reset;

   cwc_req_if req_chan ();
   cwc_rsp_if rsp_chan ();

   circular_window_correlator uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   corr_scoreboard corr_sb = new();

   // Sender idling is switched off for a stretch of the random part.
   bit          req_steady = 0;
   int          results_seen = 0;
   int          holdoff_left = 0;
   bit          holdoff_done = 0;
   int unsigned cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Bail out if the run hangs: print the failure and stop.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Pick a sample or coefficient value; favor the two extremes and zero now and then.
   function automatic logic signed [SMP_W-1:0] pick_value();
      case ($urandom_range(7))
         0: return {1'b1, {(SMP_W-1){1'b0}}};
         1: return {1'b0, {(SMP_W-1){1'b1}}};
         2: return '0;
         default: return SMP_W'($urandom);
      endcase
   endfunction

   // Offer one word on the request channel. Start at a falling edge, possibly idle at
   // random first, then hold valid until the block takes the word at a rising
   // edge. Leave valid high on return: the next call decides whether to drop it.
   task automatic send_word(input logic mode, input addr_type idx,
                            input logic signed [SMP_W-1:0] re,
                            input logic signed [SMP_W-1:0] im);
      bit taken;
      while (!req_steady && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid      = 1'b1;
      req_chan.mode       = mode;
      req_chan.coef_index = idx;
      req_chan.value_re   = re;
      req_chan.value_im   = im;
      taken = 0;
      while (!taken) begin
         @(posedge clock);
         taken = req_chan.ready;
      end
      corr_sb.note_word(mode, idx, re, im);
      @(negedge clock);
   endtask

   // Drop valid and wait until every queued lag has come out.
   task automatic wait_drained();
      req_chan.valid = 1'b0;
      while (corr_sb.lag_q.size() != 0)
         @(negedge clock);
   endtask

   // Result side: decide ready at each falling edge. Honor a pending hold-off first,
   // then idle at random except during the steady stretch of results.
   initial begin
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (holdoff_left > 0) begin
            rsp_chan.ready = 1'b0;
            holdoff_left--;
         end else if (results_seen >= 64 && results_seen < 124) begin
            rsp_chan.ready = 1'b1;
         end else begin
            rsp_chan.ready = ($urandom_range(99) >= IDLE_PCT);
         end
         @(negedge clock);
      end
   end

   // Sample the result channel at the rising edge; check every word taken.
   // Early in the first vector, arm one long hold-off so the MAC pipe freezes
   // while the sender keeps offering words of the next vector.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         corr_sb.check_result(rsp_chan.out_re, rsp_chan.out_im, rsp_chan.lag,
                              rsp_chan.last);
         results_seen++;
         if (results_seen == 20 && !holdoff_done) begin
            holdoff_left = HOLDOFF_CYCLES;
            holdoff_done = 1;
         end
      end
   end

   // Main stimulus.
   initial begin
      logic signed [SMP_W-1:0] most_neg;
      int                      n_smp;
      int                      n_word;
      most_neg = {1'b1, {(SMP_W-1){1'b0}}};

      // Hold every input at a known value through reset.
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.mode       = MODE_COEF;
      req_chan.coef_index = '0;
      req_chan.value_re   = '0;
      req_chan.value_im   = '0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // Fill every window slot before any vector can close: no lag may ever read
      // a slot that was never written. Use the most negative value everywhere so
      // the first vector drives the imaginary sum to the largest value it can reach.
      for (int i = 0; i < WIN_LEN; i++)
         send_word(MODE_COEF, addr_type'(i), most_neg, most_neg);

      // Vector of most negative samples: every product is +2^31 on the imaginary
      // side, so each lag's imaginary sum reaches its largest value, +2^37. The
      // coefficient index of a sample word is ignored, so drive it at random.
      for (int k = 0; k < WIN_LEN; k++)
         send_word(MODE_SAMPLE, addr_type'($urandom), most_neg, most_neg);

      // Random vector: samples with coefficient rewrites mixed in, some of them
      // landing in the middle of the vector (they must not disturb the count).
      // Partway through, pause until the first vector has fully drained.
      n_smp  = 0;
      n_word = 0;
      while (n_smp < WIN_LEN) begin
         if (n_word == 40)
            wait_drained();
         req_steady = (n_word >= 10 && n_word < 40);
         if ($urandom_range(99) < 20) begin
            send_word(MODE_COEF, addr_type'($urandom_range(WIN_LEN - 1)),
                      pick_value(), pick_value());
         end else begin
            send_word(MODE_SAMPLE, addr_type'($urandom), pick_value(), pick_value());
            n_smp++;
         end
         n_word++;
      end
      req_steady = 0;

      // Drain, then watch a while longer for any extra result.
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (corr_sb.errors == 0 && corr_sb.lag_q.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/cwc_pkg.sv
rtl/cwc_if.sv
rtl/cwc_ram.sv
rtl/cwc_ctrl.sv
rtl/cwc_dp.sv
rtl/circular_window_correlator.sv
dv/testbench.sv
